>>> rtl/bd2a_pkg.sv
// shared constants for the signed binary to decimal ascii converter
package bd2a_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned MAX_DIGITS = 10;
    localparam int unsigned CNT_W    = $clog2(MAX_DIGITS + 1);

    // reciprocal of ten for a 32-bit dividend: q = (x * RECIP10) >> RECIP10_SHIFT
    localparam logic [VALUE_W-1:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int unsigned        RECIP10_SHIFT = 35;
    localparam int unsigned        QUOT_W        = 2 * VALUE_W - RECIP10_SHIFT;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

endpackage

>>> rtl/bd2a_div10.sv
// shared divide-by-ten unit: quotient and remainder by reciprocal multiply
module bd2a_div10 (
    input  logic [bd2a_pkg::VALUE_W-1:0] i_x,
    output logic [bd2a_pkg::VALUE_W-1:0] o_quot,
    output logic [bd2a_pkg::DIGIT_W-1:0] o_rem
);

    logic [2*bd2a_pkg::VALUE_W-1:0] w_prod;
    logic [bd2a_pkg::QUOT_W-1:0]    w_q;
    logic [bd2a_pkg::VALUE_W-1:0]   w_q_ext;
    logic [bd2a_pkg::VALUE_W-1:0]   w_times10;
    logic [bd2a_pkg::VALUE_W-1:0]   w_diff;

    assign w_prod    = {{bd2a_pkg::VALUE_W{1'b0}}, i_x}
                     * {{bd2a_pkg::VALUE_W{1'b0}}, bd2a_pkg::RECIP10};
    assign w_q       = w_prod[2*bd2a_pkg::VALUE_W-1:bd2a_pkg::RECIP10_SHIFT];
    assign w_q_ext   = bd2a_pkg::VALUE_W'(w_q);
    // q*10 as (q<<3)+(q<<1)
    assign w_times10 = (w_q_ext << 3) + (w_q_ext << 1);
    assign w_diff    = i_x - w_times10;

    assign o_quot = w_q_ext;
    assign o_rem  = w_diff[bd2a_pkg::DIGIT_W-1:0];

endmodule

>>> rtl/signed_binary_to_decimal_ascii.sv
// top level: signed 32-bit integer in, decimal ascii character stream out
//
//  channel   dir  handshake                  payload
//  s_axis    in   i_s_axis_tvalid/o_..tready tdata[31:0] value (signed)
//  m_axis    out  o_m_axis_tvalid/i_..tready tdata[7:0] character, tlast last
//
// each item is loaded, then its decimal digits (1..10) are extracted one per cycle
// through the shared divide-by-ten unit, then its characters (1..11) are loaded
// into the output register one per cycle while the output does not stall
// i_rst_n is synchronous and active low; it clears the sequencer and output valid
// downstream stalls hold the output register and pause the character sequence;
// the input side is ready only while the sequencer is idle
module signed_binary_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] character
    output logic        o_m_axis_tlast    // last
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]                        r_state, n_state;
    logic [bd2a_pkg::VALUE_W-1:0]      r_mag, n_mag;
    logic [bd2a_pkg::CNT_W-1:0]        r_nd, n_nd;
    logic                              r_sign_pend, n_sign_pend;
    logic                              r_neg, n_neg;
    logic [bd2a_pkg::DIGIT_W-1:0]      r_digs [bd2a_pkg::MAX_DIGITS];
    logic                              r_out_valid, n_out_valid;
    logic [bd2a_pkg::CHAR_W-1:0]       r_out_char, n_out_char;
    logic                              r_out_last, n_out_last;

    logic [bd2a_pkg::VALUE_W-1:0]      w_quot;
    logic [bd2a_pkg::DIGIT_W-1:0]      w_rem;
    logic                              w_in_xfer;
    logic                              w_out_free;
    logic                              w_dig_wr;
    logic [bd2a_pkg::CNT_W-1:0]        w_nd_dec;
    logic [bd2a_pkg::DIGIT_W-1:0]      w_dig_rd;

    // shared divide unit works on the running magnitude
    bd2a_div10 u_div10 (
        .i_x    (r_mag),
        .o_quot (w_quot),
        .o_rem  (w_rem)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    // output register can take a new character this cycle
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_nd_dec        = r_nd - bd2a_pkg::CNT_W'(1);
    assign w_dig_rd        = r_digs[w_nd_dec];
    assign w_dig_wr        = (r_state == S_DIV);

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_nd        = r_nd;
        n_sign_pend = r_sign_pend;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_neg   = i_s_axis_tdata[31];
                    // two's complement magnitude; most negative value stays 2^31 unsigned
                    n_mag   = i_s_axis_tdata[31] ? (32'd0 - i_s_axis_tdata) : i_s_axis_tdata;
                    n_nd    = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // digits land least significant first
                n_mag = w_quot;
                n_nd  = r_nd + bd2a_pkg::CNT_W'(1);
                if (w_quot == '0 || r_nd == bd2a_pkg::CNT_W'(bd2a_pkg::MAX_DIGITS - 1)) begin
                    n_sign_pend = r_neg;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_sign_pend) begin
                        n_out_char  = bd2a_pkg::ASCII_MINUS;
                        n_out_last  = 1'b0;
                        n_sign_pend = 1'b0;
                    end else begin
                        // most significant digit comes out first
                        n_out_char = bd2a_pkg::ASCII_ZERO + bd2a_pkg::CHAR_W'(w_dig_rd);
                        n_out_last = (r_nd == bd2a_pkg::CNT_W'(1));
                        n_nd       = w_nd_dec;
                        if (r_nd == bd2a_pkg::CNT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nd        <= '0;
            r_sign_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nd        <= n_nd;
            r_sign_pend <= n_sign_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // digit store
    always_ff @(posedge i_clk) begin
        if (w_dig_wr) begin
            r_digs[r_nd] <= w_rem;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;
    assign o_m_axis_tlast  = r_out_last;

    // digit count never runs past the store
    a_nd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nd <= bd2a_pkg::CNT_W'(bd2a_pkg::MAX_DIGITS)))
        else $error("digit count out of range");

    // an accepted value starts a fresh digit extraction
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_DIV && r_nd == '0))
        else $error("conversion did not start");

    // emitted characters are a minus sign or a decimal digit
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_char == bd2a_pkg::ASCII_MINUS ||
                         (r_out_char >= bd2a_pkg::ASCII_ZERO &&
                          r_out_char <= bd2a_pkg::ASCII_ZERO + 8'd9)))
        else $error("bad output character");

    // the sign is never left pending once the sequencer is idle
    a_sign_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_sign_pend)
        else $error("minus sign still pending in idle");

    // loading the final digit returns the sequencer to idle with last and valid set
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free && !r_sign_pend && r_nd == bd2a_pkg::CNT_W'(1))
        |=> (r_state == S_IDLE && r_out_last && r_out_valid))
        else $error("run did not end on last character");

endmodule

>>> tb/testbench.sv
// testbench for the signed binary to decimal ascii converter
module testbench;

    // one expected output character and its end-of-number flag
    typedef struct packed {
        logic [bd2a_pkg::CHAR_W-1:0] code;
        logic                        last;
    } t_text_char;

    logic                         i_clk    = 1'b0;
    logic                         i_rst_n  = 1'b0;
    logic                         s_valid  = 1'b0;
    logic [bd2a_pkg::VALUE_W-1:0] s_data   = '0;   // [31:0] value
    logic                         m_ready  = 1'b0;
    logic                         o_s_axis_tready;
    logic                         o_m_axis_tvalid;
    logic [bd2a_pkg::CHAR_W-1:0]  o_m_axis_tdata;  // [7:0] character
    logic                         o_m_axis_tlast;  // last

    t_text_char pending_text[$];          // characters still owed by the converter
    int         error_count  = 0;
    bit         idle_on      = 1'b1;      // random gaps on both sides when set
    int         rx_hold_req  = 0;         // cycles the receiver is asked to hold off
    int         hold_left    = 0;

    signed_binary_to_decimal_ascii dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // appends the decimal text of one value, most significant character first
    function automatic void predict_decimal_text(input logic [bd2a_pkg::VALUE_W-1:0] value);
        logic [bd2a_pkg::CHAR_W-1:0]  digit_code [bd2a_pkg::MAX_DIGITS];
        logic [bd2a_pkg::VALUE_W-1:0] magnitude;
        int                           n_digits;
        t_text_char                   c;
        // magnitude as unsigned, so the most negative value comes out right
        magnitude = value[bd2a_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
        n_digits  = 0;
        do begin
            digit_code[n_digits] = bd2a_pkg::ASCII_ZERO
                                 + bd2a_pkg::CHAR_W'(magnitude % 10);
            magnitude            = magnitude / 10;
            n_digits++;
        end while (magnitude != 0 && n_digits < bd2a_pkg::MAX_DIGITS);
        if (value[bd2a_pkg::VALUE_W-1]) begin
            c.code = bd2a_pkg::ASCII_MINUS;
            c.last = 1'b0;
            pending_text.push_back(c);
        end
        for (int i = n_digits - 1; i >= 0; i--) begin
            c.code = digit_code[i];
            c.last = (i == 0);
            pending_text.push_back(c);
        end
    endfunction

    // offers one value, optionally after a random gap, and books its text on transfer
    task automatic send_value(input logic [bd2a_pkg::VALUE_W-1:0] value);
        while (idle_on && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= value;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_decimal_text(value);
    endtask

    // receiver: checks each character transfer, stalls at random or on request
    always @(posedge i_clk) begin : rx_side
        t_text_char want;
        if (rx_hold_req != 0) begin
            hold_left   = rx_hold_req;
            rx_hold_req = 0;
        end
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (pending_text.size() == 0) begin
                $error("unexpected character: actual %0d last %0b",
                       o_m_axis_tdata, o_m_axis_tlast);
                error_count++;
            end else begin
                want = pending_text.pop_front();
                if (o_m_axis_tdata !== want.code) begin
                    $error("character: expected %0d actual %0d", want.code, o_m_axis_tdata);
                    error_count++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("last: expected %0b actual %0b", want.last, o_m_axis_tlast);
                    error_count++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(idle_on && $urandom_range(99) < 29);
        end
    end

    // signed value with a chosen number of decimal digits in its magnitude
    function automatic logic [bd2a_pkg::VALUE_W-1:0] value_with_digits(input int n_digits);
        longint lo;
        longint hi;
        longint mag;
        bit     neg;
        lo  = 1;
        for (int i = 1; i < n_digits; i++) lo = lo * 10;
        hi  = (n_digits == 1) ? 9 : lo * 10 - 1;
        neg = $urandom_range(1);
        // ten-digit magnitudes stop at the 32-bit signed limits
        if (hi > 64'sd2147483647) hi = neg ? 64'sd2147483648 : 64'sd2147483647;
        if (n_digits == 1) lo = 0;
        mag = lo + longint'({$urandom, $urandom}) % (hi - lo + 1);
        if (mag < lo) mag = mag + (hi - lo + 1);
        return neg ? bd2a_pkg::VALUE_W'(-mag) : bd2a_pkg::VALUE_W'(mag);
    endfunction

    // extremes, zero, single digits, digit-count boundaries and sign flips
    task automatic test_directed();
        logic [bd2a_pkg::VALUE_W-1:0] corner [] = '{
            32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
            -32'sd100, 32'd999999999, 32'd1000000000, -32'sd999999999,
            -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
            32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890, -32'sd1234567890,
            32'hFFFF_FFFE, 32'd4294967
        };
        foreach (corner[i]) send_value(corner[i]);
    endtask

    // random values spread over every length and sign
    task automatic test_random_values(input int count);
        int     pick;
        longint p10;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(9);
            if (pick < 4) begin
                send_value($urandom);
            end else if (pick < 8) begin
                send_value(value_with_digits($urandom_range(1, 10)));
            end else if (pick == 8) begin
                // just around a power of ten, either sign
                p10 = 1;
                for (int i = $urandom_range(1, 9); i > 0; i--) p10 = p10 * 10;
                p10 = p10 + $urandom_range(2) - 1;
                send_value($urandom_range(1) ? bd2a_pkg::VALUE_W'(-p10)
                                             : bd2a_pkg::VALUE_W'(p10));
            end else begin
                send_value(bd2a_pkg::VALUE_W'($urandom_range(40) - 20));
            end
        end
    endtask

    // receiver holds off for a long time while values keep coming, so input stalls
    task automatic test_output_backpressure();
        rx_hold_req = 200;
        for (int n = 0; n < 12; n++) send_value(value_with_digits($urandom_range(1, 10)));
    endtask

    // values offered and characters taken with no random gap on either side
    task automatic test_steady_stream(input int count);
        idle_on = 1'b0;
        for (int n = 0; n < count; n++) send_value(value_with_digits($urandom_range(1, 10)));
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_values(150);
        test_output_backpressure();
        test_steady_stream(40);
        test_random_values(150);

        s_valid <= 1'b0;
        while (pending_text.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // safety net well beyond the slowest correct run
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/bd2a_pkg.sv
rtl/bd2a_div10.sv
rtl/signed_binary_to_decimal_ascii.sv
tb/testbench.sv
